>>> design/length_prefixed_message_ring_top_macros.svh
// Assertion macros for the length-prefixed message ring.
// Used by the port checker; expects clk and rst in the enclosing scope.
`ifndef LENGTH_PREFIXED_MESSAGE_RING_TOP_MACROS_SVH
`define LENGTH_PREFIXED_MESSAGE_RING_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LPMR_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpmr check failed");

// Next-cycle implication, disabled during reset
`define LPMR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpmr check failed");

`endif

>>> design/lpmr_pkg.sv
// Shared types and constants for the length-prefixed message ring.
// Used by the controller, the datapath and the top level.
package lpmr_pkg;

  localparam int RING_BYTES_DEF  = 1024;
  localparam int MAX_MESSAGE_DEF = 64;
  localparam int HDR_BYTES       = 4;
  localparam int STORED_W        = 11;
  localparam int LEN_W           = 7;
  localparam int CNT_W           = 7;
  localparam int IN_DATA_W       = 16;
  localparam int OUT_DATA_W      = 24;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_PEEK  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_LENGTH   = 2'd2,
    ST_NO_SPACE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_WR_HDR,
    S_WR_BYTE,
    S_RD_HDR,
    S_RD_EVAL,
    S_RD_DATA,
    S_RESP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    req_load;
    logic    cnt_clear;
    logic    wr_start;
    logic    hdr_wr;
    logic    wr_byte;
    logic    rd_hdr;
    logic    rd_eval;
    logic    status_load;
    status_t status_code;
    logic    emit_resp;
    logic    emit_data;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    mode_t mode;
    logic  progress_zero;
    logic  len_zero;
    logic  rejected;
    logic  empty;
    logic  hdr_done;
    logic  exceed;
    logic  stored_zero;
    logic  last_byte;
    logic  out_free;
  } stat_t;

endpackage

>>> design/length_prefixed_message_ring_top.sv
// Length-prefixed message ring: a byte ring that stores whole messages, each
// behind a 4-byte little-endian length header, written one byte per input beat
// and returned by read (frees the message) or peek (leaves it) as a run of
// result beats. Items are taken one at a time; the slave side is ready only
// while the block is idle, which it is again in the cycle after the last result
// beat of an item is loaded. A write beat goes from dispatch to its byte step and
// then to its result beat. The first byte of an accepted message first writes the
// header, one byte per cycle, since the ring RAM has a single write port; the
// first byte of a rejected message passes the header step without writing. A
// zero-length write or a read or peek of an empty ring goes from dispatch straight
// to its result beat. Any other read or peek first walks the header (four header
// reads through the registered RAM port, a step to collect the last header byte,
// then the length check); unless the check answers with a status beat, it gives
// one byte per cycle while the master side is ready. A result beat that waits on
// the master side stalls the controller.
// The ring needs no clearing after reset: only written entries are read.
// Depends on lpmr_pkg, lpmr_ctrl, lpmr_datapath and lpmr_ram.
module length_prefixed_message_ring_top #(
  parameter int RING_BYTES  = lpmr_pkg::RING_BYTES_DEF,
  parameter int MAX_MESSAGE = lpmr_pkg::MAX_MESSAGE_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [lpmr_pkg::IN_DATA_W-1:0]   s_tdata,  // [7:0] data_byte, [14:8] msg_length
  input  logic [1:0]                       s_tuser,  // [1:0] mode
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [lpmr_pkg::OUT_DATA_W-1:0]  m_tdata,  // [7:0] data_out, [18:8] stored_bytes
  output logic [2:0]                       m_tuser,  // [1:0] status, [2] is_data
  output logic                             m_tlast
);

  lpmr_pkg::cmd_t  cmd;
  lpmr_pkg::stat_t stat;

  lpmr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lpmr_datapath #(
    .RING_BYTES  (RING_BYTES),
    .MAX_MESSAGE (MAX_MESSAGE)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

>>> design/lpmr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lpmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and read port that holds its data until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/lpmr_datapath.sv
// Datapath of the message ring: pointers, write tracking, header decode,
// ring RAM and the output register. Depends on lpmr_pkg and lpmr_ram.
module lpmr_datapath #(
  parameter int RING_BYTES  = lpmr_pkg::RING_BYTES_DEF,
  parameter int MAX_MESSAGE = lpmr_pkg::MAX_MESSAGE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [lpmr_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic [1:0]                        s_tuser,
  input  lpmr_pkg::cmd_t                    cmd,
  output lpmr_pkg::stat_t                   stat,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [lpmr_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic [2:0]                        m_tuser,
  output logic                              m_tlast
);

  localparam int AW        = $clog2(RING_BYTES);
  localparam int PW        = AW + 1;
  localparam int SUM_W     = PW + 1;
  localparam int LEN_LIMIT = (MAX_MESSAGE < RING_BYTES - lpmr_pkg::HDR_BYTES) ?
                             MAX_MESSAGE : RING_BYTES - lpmr_pkg::HDR_BYTES;

  // Request latch
  lpmr_pkg::mode_t             req_mode;
  logic [7:0]                  req_byte;
  logic [lpmr_pkg::LEN_W-1:0]  req_len;

  // Ring state
  logic [PW-1:0]               rp;
  logic [PW-1:0]               wp;
  logic [lpmr_pkg::LEN_W-1:0]  progress;
  logic [lpmr_pkg::LEN_W-1:0]  total;
  logic                        rejected;

  // Shared step counter and header decode
  logic [lpmr_pkg::CNT_W-1:0]  cnt;
  logic [7:0]                  len_lo;
  logic                        len_hi;
  logic [AW-1:0]               base;
  lpmr_pkg::status_t           resp_status;

  // Output register
  logic                        out_valid;
  lpmr_pkg::status_t           out_status;
  logic                        out_is_data;
  logic [7:0]                  out_data;
  logic                        out_last;
  logic [lpmr_pkg::STORED_W-1:0] out_stored;

  // RAM ports
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [7:0]                  ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [7:0]                  ram_rdata;

  // Derived values
  logic [PW-1:0]               used;
  logic                        space_fail;
  logic                        too_long;
  logic                        total_long;
  logic [lpmr_pkg::LEN_W-1:0]  progress_next;
  logic                        write_done;
  logic                        exceed;
  logic                        stored_zero;
  logic                        last_byte;
  logic                        hdr_done;
  logic                        out_free;

  // Occupancy, space check and header checks
  always_comb begin
    used          = wp - rp;
    space_fail    = (SUM_W'(used) + SUM_W'(lpmr_pkg::HDR_BYTES) + SUM_W'(req_len)) >
                    SUM_W'(RING_BYTES);
    too_long      = req_len > lpmr_pkg::LEN_W'(MAX_MESSAGE);
    total_long    = total > lpmr_pkg::LEN_W'(MAX_MESSAGE);
    progress_next = progress + 1'b1;
    write_done    = progress_next >= total;
    exceed        = len_hi || (len_lo > 8'(LEN_LIMIT)) || (len_lo > {1'b0, req_len});
    stored_zero   = (len_lo == 8'd0);
    last_byte     = (8'(cnt) + 8'd1) == len_lo;
    hdr_done      = (cnt == lpmr_pkg::CNT_W'(lpmr_pkg::HDR_BYTES));
    out_free      = !out_valid || m_tready;
  end

  // Status toward the controller
  always_comb begin
    stat.mode          = req_mode;
    stat.progress_zero = (progress == '0);
    stat.len_zero      = (req_len == '0);
    stat.rejected      = rejected;
    stat.empty         = used <= PW'(lpmr_pkg::HDR_BYTES);
    stat.hdr_done      = hdr_done;
    stat.exceed        = exceed;
    stat.stored_zero   = stored_zero;
    stat.last_byte     = last_byte;
    stat.out_free      = out_free;
  end

  // Write port: header bytes, then message bytes of an accepted message
  always_comb begin
    ram_we = (cmd.hdr_wr || cmd.wr_byte) && !rejected;
    if (cmd.hdr_wr) begin
      ram_waddr = wp[AW-1:0] + AW'(cnt);
      ram_wdata = (cnt == '0) ? {1'b0, total} : 8'h00;
    end else begin
      ram_waddr = wp[AW-1:0] + AW'(lpmr_pkg::HDR_BYTES) + AW'(progress);
      ram_wdata = req_byte;
    end
  end

  // Read port: header walk, first body byte, then one byte per emitted beat
  always_comb begin
    ram_re = (cmd.rd_hdr && (cnt < lpmr_pkg::CNT_W'(lpmr_pkg::HDR_BYTES))) ||
             (cmd.rd_eval && !exceed && !stored_zero) ||
             (cmd.emit_data && !last_byte);
    priority if (cmd.rd_hdr) begin
      ram_raddr = rp[AW-1:0] + AW'(cnt);
    end else if (cmd.rd_eval) begin
      ram_raddr = rp[AW-1:0] + AW'(lpmr_pkg::HDR_BYTES);
    end else begin
      ram_raddr = base + AW'(cnt) + AW'(1);
    end
  end

  lpmr_ram #(
    .WIDTH (8),
    .DEPTH (RING_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Latch the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_mode <= lpmr_pkg::mode_t'(s_tuser);
      req_byte <= s_tdata[7:0];
      req_len  <= s_tdata[8 +: lpmr_pkg::LEN_W];
    end
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clear || cmd.rd_eval) begin
      cnt <= '0;
    end else if (cmd.hdr_wr || cmd.rd_hdr || cmd.emit_data) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Collect the stored length from the header bytes
  always_ff @(posedge clk) begin
    if (cmd.cnt_clear) begin
      len_hi <= 1'b0;
    end else if (cmd.rd_hdr) begin
      if (cnt == lpmr_pkg::CNT_W'(1)) begin
        len_lo <= ram_rdata;
      end else if (cnt >= lpmr_pkg::CNT_W'(2)) begin
        len_hi <= len_hi || (ram_rdata != 8'h00);
      end
    end
  end

  // Write tracking, commit and read advance
  always_ff @(posedge clk) begin
    if (rst) begin
      rp       <= '0;
      wp       <= '0;
      progress <= '0;
      total    <= '0;
      rejected <= 1'b0;
    end else begin
      if (cmd.wr_start) begin
        total    <= req_len;
        rejected <= too_long || space_fail;
      end
      if (cmd.wr_byte) begin
        progress <= write_done ? '0 : progress_next;
        if (write_done && !rejected) begin
          wp <= wp + PW'(lpmr_pkg::HDR_BYTES) + PW'(total);
        end
        if (write_done) begin
          rejected <= 1'b0;
        end
      end
      if (cmd.rd_eval && (req_mode == lpmr_pkg::MODE_READ) && !exceed) begin
        rp <= rp + PW'(lpmr_pkg::HDR_BYTES) + PW'(len_lo);
      end
    end
  end

  // Hold the body start and the pending response code
  always_ff @(posedge clk) begin
    if (cmd.rd_eval) begin
      base <= rp[AW-1:0] + AW'(lpmr_pkg::HDR_BYTES);
    end
    if (cmd.status_load) begin
      resp_status <= cmd.status_code;
    end else if (cmd.wr_byte) begin
      if (rejected) begin
        resp_status <= total_long ? lpmr_pkg::ST_LENGTH : lpmr_pkg::ST_NO_SPACE;
      end else begin
        resp_status <= lpmr_pkg::ST_OK;
      end
    end
  end

  // Output register: load a result beat, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_resp || cmd.emit_data) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_resp) begin
      out_status  <= resp_status;
      out_is_data <= 1'b0;
      out_data    <= 8'h00;
      out_last    <= 1'b1;
      out_stored  <= lpmr_pkg::STORED_W'(used);
    end else if (cmd.emit_data) begin
      out_status  <= lpmr_pkg::ST_OK;
      out_is_data <= 1'b1;
      out_data    <= ram_rdata;
      out_last    <= last_byte;
      out_stored  <= lpmr_pkg::STORED_W'(used);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_stored, out_data};
  assign m_tuser  = {out_is_data, out_status};
  assign m_tlast  = out_last;

endmodule

>>> design/lpmr_ctrl.sv
// Controller state machine of the message ring.
// Drives datapath commands from its status; depends on lpmr_pkg.
module lpmr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  lpmr_pkg::stat_t stat,
  output lpmr_pkg::cmd_t  cmd
);

  lpmr_pkg::state_t state;
  lpmr_pkg::state_t state_next;
  logic             is_write;
  logic             is_read;

  assign is_write = (stat.mode == lpmr_pkg::MODE_WRITE);
  assign is_read  = (stat.mode == lpmr_pkg::MODE_READ) || (stat.mode == lpmr_pkg::MODE_PEEK);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpmr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lpmr_pkg::S_IDLE: begin
        if (s_tvalid) begin
          state_next = lpmr_pkg::S_DISPATCH;
        end
      end
      lpmr_pkg::S_DISPATCH: begin
        if (is_write) begin
          if (!stat.progress_zero) begin
            state_next = lpmr_pkg::S_WR_BYTE;
          end else if (stat.len_zero) begin
            state_next = lpmr_pkg::S_RESP;
          end else begin
            state_next = lpmr_pkg::S_WR_HDR;
          end
        end else if (is_read) begin
          state_next = stat.empty ? lpmr_pkg::S_RESP : lpmr_pkg::S_RD_HDR;
        end else begin
          state_next = lpmr_pkg::S_IDLE;
        end
      end
      lpmr_pkg::S_WR_HDR: begin
        if (stat.rejected || stat.hdr_done) begin
          state_next = lpmr_pkg::S_WR_BYTE;
        end
      end
      lpmr_pkg::S_WR_BYTE: state_next = lpmr_pkg::S_RESP;
      lpmr_pkg::S_RD_HDR: begin
        if (stat.hdr_done) begin
          state_next = lpmr_pkg::S_RD_EVAL;
        end
      end
      lpmr_pkg::S_RD_EVAL: begin
        state_next = (stat.exceed || stat.stored_zero) ? lpmr_pkg::S_RESP :
                                                         lpmr_pkg::S_RD_DATA;
      end
      lpmr_pkg::S_RD_DATA: begin
        if (stat.out_free && stat.last_byte) begin
          state_next = lpmr_pkg::S_IDLE;
        end
      end
      lpmr_pkg::S_RESP: begin
        if (stat.out_free) begin
          state_next = lpmr_pkg::S_IDLE;
        end
      end
      default: state_next = lpmr_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd             = '0;
    cmd.status_code = lpmr_pkg::ST_OK;
    s_tready        = 1'b0;
    unique case (state)
      lpmr_pkg::S_IDLE: begin
        s_tready     = 1'b1;
        cmd.req_load = s_tvalid;
      end
      lpmr_pkg::S_DISPATCH: begin
        cmd.cnt_clear = 1'b1;
        if (is_write && stat.progress_zero) begin
          if (stat.len_zero) begin
            cmd.status_load = 1'b1;
            cmd.status_code = lpmr_pkg::ST_OK;
          end else begin
            cmd.wr_start = 1'b1;
          end
        end else if (is_read && stat.empty) begin
          cmd.status_load = 1'b1;
          cmd.status_code = lpmr_pkg::ST_EMPTY;
        end
      end
      lpmr_pkg::S_WR_HDR: cmd.hdr_wr = !stat.rejected && !stat.hdr_done;
      lpmr_pkg::S_WR_BYTE: cmd.wr_byte = 1'b1;
      lpmr_pkg::S_RD_HDR: cmd.rd_hdr = 1'b1;
      lpmr_pkg::S_RD_EVAL: begin
        cmd.rd_eval = 1'b1;
        if (stat.exceed) begin
          cmd.status_load = 1'b1;
          cmd.status_code = lpmr_pkg::ST_LENGTH;
        end else if (stat.stored_zero) begin
          cmd.status_load = 1'b1;
          cmd.status_code = lpmr_pkg::ST_OK;
        end
      end
      lpmr_pkg::S_RD_DATA: cmd.emit_data = stat.out_free;
      lpmr_pkg::S_RESP: cmd.emit_resp = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

>>> design/lpmr_checker.sv
// Port-level checks of the message ring, bound to the top level.
// Depends on lpmr_pkg and the assertion macro header.
`include "length_prefixed_message_ring_top_macros.svh"

module lpmr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [lpmr_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [2:0]                      m_tuser,
  input logic                            m_tlast
);

  // A stalled result beat holds
  `LPMR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

  // Message bytes only come with an ok status
  `LPMR_ASSERT_IMPLY(a_data_ok, m_tvalid && m_tuser[2], m_tuser[1:0] == lpmr_pkg::ST_OK)

  // A status-only beat ends its run and carries a zero byte
  `LPMR_ASSERT_IMPLY(a_resp_last, m_tvalid && !m_tuser[2], m_tlast && (m_tdata[7:0] == 8'h00))

  // Input is not taken in the cycle right after a beat is accepted
  `LPMR_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)

endmodule

bind length_prefixed_message_ring_top lpmr_checker u_checker (.*);

>>> sim/tb_length_prefixed_message_ring_top.sv
// Self-checking testbench for the length-prefixed message ring top level.
// Drives write, read and peek beats on the slave stream, predicts every result
// beat from its own ring model and compares it on the master stream. Needs lpmr_pkg.
`timescale 1ns / 100ps

module tb_length_prefixed_message_ring_top;

  localparam int RING   = lpmr_pkg::RING_BYTES_DEF;
  localparam int MAXMSG = lpmr_pkg::MAX_MESSAGE_DEF;
  localparam int HDR    = lpmr_pkg::HDR_BYTES;
  localparam int SW     = lpmr_pkg::STORED_W;
  localparam int AMASK  = RING - 1;
  localparam int PMASK  = 2 * RING - 1;
  localparam int unsigned RUN_LIMIT_NS = 5_000_000;

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [lpmr_pkg::IN_DATA_W-1:0]  s_tdata;   // [7:0] data_byte, [14:8] msg_length
  logic [1:0]                      s_tuser;   // [1:0] mode
  logic                            m_tvalid;
  logic                            m_tready;
  logic [lpmr_pkg::OUT_DATA_W-1:0] m_tdata;   // [7:0] data_out, [18:8] stored_bytes
  logic [2:0]                      m_tuser;   // [1:0] status, [2] is_data
  logic                            m_tlast;

  length_prefixed_message_ring_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  typedef struct {
    lpmr_pkg::status_t status;
    logic              is_data;
    logic [7:0]        data;
    logic              is_last;
    logic [SW-1:0]     stored;
  } ring_beat_t;

  // Shadow ring and pointers
  logic [7:0] ring_mem [RING];
  int         rd_ptr, wr_ptr, wr_count, wr_len;
  bit         wr_reject;
  ring_beat_t pending_beats[$];

  bit calm;
  int mismatches, beats_checked;
  int n_write, n_read, n_peek, n_ignored;
  int status_seen [4];

  function automatic int ring_used();
    return (wr_ptr - rd_ptr) & PMASK;
  endfunction

  function automatic void push_beat(lpmr_pkg::status_t st, logic is_data, logic [7:0] d,
                                    logic lst);
    ring_beat_t b;
    b.status  = st;
    b.is_data = is_data;
    b.data    = d;
    b.is_last = lst;
    b.stored  = SW'(ring_used());
    pending_beats.push_back(b);
  endfunction

  // Advance the shadow ring by one accepted beat and queue its results
  function automatic void ring_predict(lpmr_pkg::mode_t m, logic [7:0] b, logic [6:0] n);
    int                k, len, start;
    lpmr_pkg::status_t st;
    case (m)
      lpmr_pkg::MODE_WRITE: begin
        if (wr_count == 0) begin
          wr_len = n;
          if (wr_len == 0) begin
            push_beat(lpmr_pkg::ST_OK, 1'b0, 8'h00, 1'b1);
            return;
          end
          wr_reject = (wr_len > MAXMSG) || (ring_used() + HDR + wr_len > RING);
          if (!wr_reject) begin
            for (k = 0; k < HDR; k++) ring_mem[(wr_ptr + k) & AMASK] = 8'(wr_len >> (8 * k));
          end
        end
        if (!wr_reject) ring_mem[(wr_ptr + HDR + wr_count) & AMASK] = b;
        wr_count++;
        if (wr_count >= wr_len) begin
          if (!wr_reject) wr_ptr = (wr_ptr + HDR + wr_len) & PMASK;
          wr_count = 0;
        end
        st = lpmr_pkg::ST_OK;
        if (wr_reject) st = (wr_len > MAXMSG) ? lpmr_pkg::ST_LENGTH : lpmr_pkg::ST_NO_SPACE;
        if (wr_count == 0) wr_reject = 1'b0;
        push_beat(st, 1'b0, 8'h00, 1'b1);
      end
      lpmr_pkg::MODE_READ, lpmr_pkg::MODE_PEEK: begin
        if (ring_used() <= HDR) begin
          push_beat(lpmr_pkg::ST_EMPTY, 1'b0, 8'h00, 1'b1);
          return;
        end
        len = 0;
        for (k = 0; k < HDR; k++) len |= int'(ring_mem[(rd_ptr + k) & AMASK]) << (8 * k);
        if (len > RING - HDR || len > MAXMSG || len > int'(n)) begin
          push_beat(lpmr_pkg::ST_LENGTH, 1'b0, 8'h00, 1'b1);
          return;
        end
        start = rd_ptr;
        if (m == lpmr_pkg::MODE_READ) rd_ptr = (rd_ptr + HDR + len) & PMASK;
        if (len == 0) begin
          push_beat(lpmr_pkg::ST_OK, 1'b0, 8'h00, 1'b1);
          return;
        end
        for (k = 0; k < len; k++)
          push_beat(lpmr_pkg::ST_OK, 1'b1, ring_mem[(start + HDR + k) & AMASK], k + 1 == len);
      end
      default: ;
    endcase
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Random backpressure on the result stream
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= calm || ($urandom_range(0, 99) >= 19);
    end
  end

  // Check each result beat against the oldest prediction
  always @(posedge clk) begin
    ring_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result beat: status %0d is_data %0d data %02h",
                   $realtime, m_tuser[1:0], m_tuser[2], m_tdata[7:0],
                   " last %0d stored %0d", m_tlast, m_tdata[18:8]);
      end else begin
        want = pending_beats.pop_front();
        beats_checked++;
        status_seen[m_tuser[1:0]]++;
        if (want.status !== lpmr_pkg::status_t'(m_tuser[1:0]) || want.is_data !== m_tuser[2] ||
            want.data !== m_tdata[7:0] || want.is_last !== m_tlast ||
            want.stored !== m_tdata[18:8]) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: mismatch: expected status %0d is_data %0d data %02h last %0d",
                     $realtime, want.status, want.is_data, want.data, want.is_last,
                     " stored %0d", want.stored);
            $display("    got status %0d is_data %0d data %02h last %0d stored %0d",
                     m_tuser[1:0], m_tuser[2], m_tdata[7:0], m_tlast, m_tdata[18:8]);
          end
        end
      end
    end
  end

  // Present one beat from a falling edge, hold until accepted, predict it
  task automatic send_item(lpmr_pkg::mode_t m, logic [7:0] b, logic [6:0] n);
    if (!calm && $urandom_range(0, 99) < 19) repeat ($urandom_range(1, 10)) @(negedge clk);
    s_tuser  = m;
    s_tdata  = {1'b0, n, b};
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ring_predict(m, b, n);
    case (m)
      lpmr_pkg::MODE_WRITE: n_write++;
      lpmr_pkg::MODE_READ:  n_read++;
      lpmr_pkg::MODE_PEEK:  n_peek++;
      default:              n_ignored++;
    endcase
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // Read or peek with a random capacity, mostly large enough
  task automatic send_query();
    logic [6:0] cap;
    cap = ($urandom_range(0, 99) < 70) ? 7'($urandom_range(64, 127)) : 7'($urandom_range(0, 64));
    send_item($urandom_range(0, 1) ? lpmr_pkg::MODE_READ : lpmr_pkg::MODE_PEEK,
              8'($urandom), cap);
  endtask

  // Stream one message; queries may cut in between its bytes
  task automatic write_message(int len, int cut_in_pct);
    int k;
    if (len == 0) begin
      send_item(lpmr_pkg::MODE_WRITE, 8'($urandom), 7'd0);
      return;
    end
    for (k = 0; k < len; k++) begin
      if (k > 0 && $urandom_range(0, 99) < cut_in_pct) send_query();
      send_item(lpmr_pkg::MODE_WRITE, 8'($urandom), (k == 0) ? 7'(len) : 7'($urandom));
    end
  endtask

  function automatic int rand_msg_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return $urandom_range(1, 8);
    if (pick < 90) return $urandom_range(9, 32);
    return $urandom_range(33, MAXMSG);
  endfunction

  // Empty ring, zero-length write, ignored mode, queries during a write, capacity limits
  task automatic test_directed();
    send_item(lpmr_pkg::MODE_READ,  8'h00, 7'd0);
    send_item(lpmr_pkg::MODE_PEEK,  8'hFF, 7'h7F);
    send_item(lpmr_pkg::MODE_NONE,  8'hFF, 7'h7F);
    send_item(lpmr_pkg::MODE_WRITE, 8'h5A, 7'd0);
    send_item(lpmr_pkg::MODE_WRITE, 8'hFF, 7'd1);
    send_item(lpmr_pkg::MODE_WRITE, 8'h00, 7'd2);
    send_item(lpmr_pkg::MODE_WRITE, 8'h80, 7'h7F);
    send_item(lpmr_pkg::MODE_WRITE, 8'hA5, 7'd3);
    // only committed messages are visible while the third one is open
    send_item(lpmr_pkg::MODE_PEEK,  8'h00, 7'd64);
    send_item(lpmr_pkg::MODE_READ,  8'h00, 7'd0);
    send_item(lpmr_pkg::MODE_WRITE, 8'h3C, 7'h40);
    send_item(lpmr_pkg::MODE_WRITE, 8'hC3, 7'd0);
    send_item(lpmr_pkg::MODE_PEEK,  8'h00, 7'd1);
    send_item(lpmr_pkg::MODE_READ,  8'h00, 7'd1);
    send_item(lpmr_pkg::MODE_READ,  8'h00, 7'd1);
    send_item(lpmr_pkg::MODE_PEEK,  8'h00, 7'd2);
    send_item(lpmr_pkg::MODE_READ,  8'h00, 7'd2);
    send_item(lpmr_pkg::MODE_READ,  8'h00, 7'h7F);
    send_item(lpmr_pkg::MODE_PEEK,  8'h00, 7'd64);
  endtask

  // Message longer than the limit: every byte swallowed with a length error
  task automatic test_too_long();
    write_message(MAXMSG + 1, 0);
    write_message(2, 0);
    send_item(lpmr_pkg::MODE_READ, 8'h00, 7'd2);
  endtask

  // Mixed traffic; a stretch in the middle runs without idling
  task automatic test_random_traffic(int target);
    int start, done, pick;
    start = n_write + n_read + n_peek;
    done  = 0;
    while (done < target) begin
      calm = (done >= 20 && done < 50);
      pick = $urandom_range(0, 99);
      if (pick < 45)      write_message(rand_msg_len(), 10);
      else if (pick < 65) send_item(lpmr_pkg::MODE_READ, 8'($urandom),
                                    7'($urandom_range(64, 127)));
      else if (pick < 80) send_item(lpmr_pkg::MODE_PEEK, 8'($urandom),
                                    7'($urandom_range(32, 127)));
      else if (pick < 86) write_message(0, 0);
      else if (pick < 91) send_item(lpmr_pkg::MODE_NONE, 8'($urandom), 7'($urandom));
      else if (pick < 92) write_message($urandom_range(MAXMSG + 1, MAXMSG + 6), 0);
      else                send_item($urandom_range(0, 1) ? lpmr_pkg::MODE_READ :
                                                           lpmr_pkg::MODE_PEEK,
                                    8'($urandom), 7'($urandom_range(0, 8)));
      done = n_write + n_read + n_peek - start;
    end
    calm = 1'b0;
  endtask

  // Run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("Run limit reached with %0d result beats outstanding", pending_beats.size());
    $display("TEST FAILED");
    $finish;
  end

  // Main sequence
  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = lpmr_pkg::MODE_WRITE;
    calm      = 1'b0;
    rd_ptr    = 0;
    wr_ptr    = 0;
    wr_count  = 0;
    wr_len    = 0;
    wr_reject = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_too_long();
    test_random_traffic(80);

    // drain outstanding results, then allow for trailing latency
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d write, %0d read, %0d peek and %0d ignored input beats;",
             n_write, n_read, n_peek, n_ignored);
    $display("%0d result beats checked, status mix: ok %0d, empty %0d, bad length %0d.",
             beats_checked, status_seen[lpmr_pkg::ST_OK], status_seen[lpmr_pkg::ST_EMPTY],
             status_seen[lpmr_pkg::ST_LENGTH]);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d result beats never seen", mismatches, pending_beats.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/lpmr_pkg.sv
design/lpmr_ram.sv
design/lpmr_datapath.sv
design/lpmr_ctrl.sv
design/length_prefixed_message_ring_top.sv
design/lpmr_checker.sv
sim/tb_length_prefixed_message_ring_top.sv
